// ===== hdl/uess_pkg.sv =====
`timescale 1ns / 1ps

package uess_pkg;

  typedef enum logic [2:0] {
    CMD_CONNECT    = 3'd0,
    CMD_DISCONNECT = 3'd1,
    CMD_QUERY      = 3'd2,
    CMD_NEIGHBOURS = 3'd3,
    CMD_ACTIVE     = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  listed_vertex;
    logic        listed_valid;
    logic        last;
    logic [6:0]  vertex_count;
    logic [11:0] edge_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;      // take the input item
    logic rd_en;        // read a matrix row
    logic rd_sel_b;     // read row of vertex_b instead of the incoming vertex_a
    logic load_row;     // mask takes the row just read
    logic load_active;  // mask takes the active vertex flags
    logic write_a;      // update row of vertex_a
    logic write_b;      // update row of vertex_b
    logic emit_result;  // single result for update, query or unknown command
    logic emit_list;    // one list result from the mask
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] in_command;
    logic [2:0] command;
    logic       change;
    logic       a_eq_b;
    logic       mask_empty;
    logic       rest_empty;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== hdl/undirected_edge_set_store.sv =====
`timescale 1ns / 1ps

// undirected edge set store: adjacency bit matrix over VERTEX_COUNT vertices
// input channel in_valid_i / in_ready_o carries one command item
// (connect, disconnect, query edge, list neighbours, list active vertices)
// output channel out_valid_o / out_ready_i carries result items; each item
// gives one or more results, the final one marked last, all with both counts
// one item is processed at a time; in_ready_o is high only while the
// controller is idle, and it stays high while a finished result waits
// connect or disconnect reads both rows, the second row write only when the
// edge changes between two distinct vertices; a list gives one listed vertex
// per cycle while the receiver keeps taking results
// the next item is taken the cycle after the last result is loaded
// a stalled receiver holds the result register; the block waits with it
// reset clears the per-vertex active flags and both counts; a row whose
// flag is clear reads as empty, so no clearing pass over the matrix is needed
module undirected_edge_set_store #(
  parameter int VERTEX_COUNT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  uess_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output uess_pkg::out_item_t out_o
);

  uess_pkg::ctrl_cmd_t  ctrl_cmd;
  uess_pkg::dp_status_t dp_status;

  uess_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  uess_dp #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ===== hdl/uess_ram.sv =====
`timescale 1ns / 1ps

module uess_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/uess_ctrl.sv =====
`timescale 1ns / 1ps

module uess_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  uess_pkg::dp_status_t  status_i,
  output uess_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ROW_A  = 6'b000010,
    S_UPD_A  = 6'b000100,
    S_UPD_B  = 6'b001000,
    S_RESULT = 6'b010000,
    S_LIST   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   is_update;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign is_update = (status_i.command == uess_pkg::CMD_CONNECT) ||
                     (status_i.command == uess_pkg::CMD_DISCONNECT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (status_i.in_command == uess_pkg::CMD_ACTIVE) begin
            cmd_o.load_active = 1'b1;
            state_d           = S_LIST;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_ROW_A;
          end
        end
      end
      S_ROW_A: begin
        cmd_o.load_row = 1'b1;
        if (is_update) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_sel_b = 1'b1;
          state_d        = S_UPD_A;
        end else if (status_i.command == uess_pkg::CMD_NEIGHBOURS) begin
          state_d = S_LIST;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_UPD_A: begin
        cmd_o.write_a = status_i.change;
        state_d = (status_i.change && !status_i.a_eq_b) ? S_UPD_B : S_RESULT;
      end
      S_UPD_B: begin
        cmd_o.write_b = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.emit_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_LIST: begin
        if (status_i.out_free) begin
          cmd_o.emit_list = 1'b1;
          if (status_i.mask_empty || status_i.rest_empty) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // second row update only ever follows the first
  a_upd_b_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD_B) |-> ($past(state_q) == S_UPD_A && $past(status_i.change)))
    else $error("row b update without a changing row a update");

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_result || cmd_o.emit_list) |-> status_i.out_free)
    else $error("result loaded over a pending item");

  // no new item while the previous one is still in progress
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !in_ready_o)
    else $error("item accepted back to back in sequential controller");

endmodule

// ===== hdl/uess_dp.sv =====
`timescale 1ns / 1ps

module uess_dp #(
  parameter int VERTEX_COUNT = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  uess_pkg::in_item_t   in_i,
  input  uess_pkg::ctrl_cmd_t  cmd_i,
  output uess_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output uess_pkg::out_item_t  out_o
);

  localparam int Aw       = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int MaxEdges = VERTEX_COUNT * (VERTEX_COUNT + 1) / 2;

  logic [2:0]              command_q;
  logic [5:0]              vertex_a_q, vertex_b_q;
  logic [VERTEX_COUNT-1:0] mask_q, mask_d;
  logic [VERTEX_COUNT-1:0] active_q, active_d;
  logic [6:0]              vcount_q, vcount_d;
  logic [11:0]             ecount_q, ecount_d;
  logic                    out_valid_q;
  uess_pkg::out_item_t     out_q, out_d;

  logic [Aw-1:0]           a_idx, b_idx, rd_addr, wr_addr;
  logic                    a_ok, b_ok, ab_ok, bit_ab, is_connect;
  logic [VERTEX_COUNT-1:0] rd_data, wr_data, row_b, bit_b_v, bit_a_v;
  logic [VERTEX_COUNT-1:0] low_oh, rest;
  logic [5:0]              low_idx;
  logic                    found, out_free, wr_en;

  assign a_idx      = vertex_a_q[Aw-1:0];
  assign b_idx      = vertex_b_q[Aw-1:0];
  assign a_ok       = 7'(vertex_a_q) < 7'(VERTEX_COUNT);
  assign b_ok       = 7'(vertex_b_q) < 7'(VERTEX_COUNT);
  assign ab_ok      = a_ok && b_ok;
  assign bit_ab     = mask_q[b_idx];
  assign is_connect = (command_q == uess_pkg::CMD_CONNECT);
  assign bit_b_v    = VERTEX_COUNT'(1) << b_idx;
  assign bit_a_v    = VERTEX_COUNT'(1) << a_idx;

  assign rd_addr = cmd_i.rd_sel_b ? b_idx : in_i.vertex_a[Aw-1:0];
  assign wr_en   = cmd_i.write_a || cmd_i.write_b;
  assign wr_addr = cmd_i.write_b ? b_idx : a_idx;
  assign row_b   = active_q[b_idx] ? rd_data : '0;

  always_comb begin
    if (cmd_i.write_b) begin
      wr_data = is_connect ? (row_b | bit_a_v) : (row_b & ~bit_a_v);
    end else begin
      wr_data = is_connect ? (mask_q | bit_b_v) : (mask_q & ~bit_b_v);
    end
  end

  uess_ram #(
    .WIDTH (VERTEX_COUNT),
    .DEPTH (VERTEX_COUNT)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // lowest set vertex of the mask
  assign low_oh = mask_q & (~mask_q + VERTEX_COUNT'(1));
  assign rest   = mask_q & ~low_oh;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < VERTEX_COUNT; i++) begin
      if (low_oh[i]) begin
        low_idx = low_idx | 6'(i);
      end
    end
  end

  always_comb begin
    found = 1'b0;
    case (command_q) inside
      uess_pkg::CMD_QUERY, uess_pkg::CMD_DISCONNECT: found = ab_ok && bit_ab;
      uess_pkg::CMD_CONNECT:                         found = ab_ok && !bit_ab;
      default:                                       found = 1'b0;
    endcase
  end

  // the active flag marks a row that holds data; a row whose flag is clear reads as empty
  always_comb begin
    mask_d   = mask_q;
    active_d = active_q;
    vcount_d = vcount_q;
    ecount_d = ecount_q;
    if (cmd_i.load_active) begin
      mask_d = active_q;
    end else if (cmd_i.load_row) begin
      mask_d = (a_ok && active_q[a_idx]) ? rd_data : '0;
    end else if (cmd_i.emit_list) begin
      mask_d = rest;
    end
    if (wr_en) begin
      active_d[wr_addr] = |wr_data;
      vcount_d = vcount_q + 7'(|wr_data) - 7'(active_q[wr_addr]);
    end
    if (cmd_i.write_a) begin
      ecount_d = is_connect ? ecount_q + 12'd1 : ecount_q - 12'd1;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_d = out_q;
    if (cmd_i.emit_result) begin
      out_d.found         = found;
      out_d.listed_vertex = '0;
      out_d.listed_valid  = 1'b0;
      out_d.last          = 1'b1;
      out_d.vertex_count  = vcount_q;
      out_d.edge_count    = ecount_q;
    end else if (cmd_i.emit_list) begin
      out_d.found         = 1'b0;
      out_d.listed_vertex = low_idx;
      out_d.listed_valid  = |mask_q;
      out_d.last          = ~|rest;
      out_d.vertex_count  = vcount_q;
      out_d.edge_count    = ecount_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      vcount_q    <= '0;
      ecount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      vcount_q <= vcount_d;
      ecount_q <= ecount_d;
      if (cmd_i.emit_result || cmd_i.emit_list) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      command_q  <= in_i.command;
      vertex_a_q <= in_i.vertex_a;
      vertex_b_q <= in_i.vertex_b;
    end
    mask_q <= mask_d;
    out_q  <= out_d;
  end

  assign status_o.in_command = in_i.command;
  assign status_o.command    = command_q;
  assign status_o.change     = found;
  assign status_o.a_eq_b     = (vertex_a_q == vertex_b_q);
  assign status_o.mask_empty = ~|mask_q;
  assign status_o.rest_empty = ~|rest;
  assign status_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // the vertex count always agrees with the active flags
  a_vcount_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(active_q)) == 32'(vcount_q))
    else $error("vertex count out of step with active flags");

  // edge count never exceeds a full graph with self-loops
  a_ecount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecount_q) <= 32'(MaxEdges))
    else $error("edge count beyond possible maximum");

endmodule

// ===== test/undirected_edge_set_store_checker.sv =====
`timescale 1ns / 1ps

module undirected_edge_set_store_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  uess_pkg::in_item_t  in_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  uess_pkg::out_item_t out_i,
  output int                  error_count_o,
  output int                  results_waiting_o,
  output int                  results_seen_o,
  output int                  longest_list_o
);

  localparam int VERTICES = 64;

  logic [63:0]         adj_rows [VERTICES];
  logic [6:0]          vertex_total;
  logic [11:0]         edge_total;
  uess_pkg::out_item_t pending_graph_results [$];
  int                  mismatches;
  int                  results_seen;
  int                  longest_list;

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      log_mismatch($sformatf("%s got %0d expected %0d (result %0d)",
                             name, got, want, results_seen));
    end
  endtask

  function automatic uess_pkg::out_item_t graph_result(input logic hit,
                                                       input logic [5:0] vtx,
                                                       input logic valid,
                                                       input logic fin);
    uess_pkg::out_item_t r;
    r.found         = hit;
    r.listed_vertex = vtx;
    r.listed_valid  = valid;
    r.last          = fin;
    r.vertex_count  = vertex_total;
    r.edge_count    = edge_total;
    return r;
  endfunction

  task automatic apply_graph_command(input uess_pkg::in_item_t it);
    logic [5:0]  a;
    logic [5:0]  b;
    logic        hit;
    logic        is_list;
    logic [63:0] list_mask;
    int          n;
    a = it.vertex_a;
    b = it.vertex_b;
    hit = 1'b0;
    is_list = 1'b0;
    list_mask = '0;
    n = 0;
    case (it.command)
      uess_pkg::CMD_CONNECT: begin
        if (!adj_rows[a][b]) begin
          if (adj_rows[a] == '0) vertex_total++;
          if (b != a && adj_rows[b] == '0) vertex_total++;
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
          edge_total++;
          hit = 1'b1;
        end
      end
      uess_pkg::CMD_DISCONNECT: begin
        if (adj_rows[a][b]) begin
          adj_rows[a][b] = 1'b0;
          adj_rows[b][a] = 1'b0;
          edge_total--;
          if (adj_rows[a] == '0) vertex_total--;
          // a self-loop only ever counted its vertex once
          if (b != a && adj_rows[b] == '0) vertex_total--;
          hit = 1'b1;
        end
      end
      uess_pkg::CMD_QUERY: hit = adj_rows[a][b];
      uess_pkg::CMD_NEIGHBOURS: begin
        is_list = 1'b1;
        list_mask = adj_rows[a];
      end
      uess_pkg::CMD_ACTIVE: begin
        is_list = 1'b1;
        for (int v = 0; v < VERTICES; v++) list_mask[v] = |adj_rows[v];
      end
      default: ;
    endcase
    if (is_list) begin
      for (int v = 0; v < VERTICES; v++) begin
        if (list_mask[v]) begin
          pending_graph_results.push_back(
            graph_result(1'b0, 6'(v), 1'b1, (list_mask >> (v + 1)) == '0));
          n++;
        end
      end
      if (n > longest_list) longest_list = n;
      // empty list still closes the item with one result
      if (n == 0) pending_graph_results.push_back(graph_result(1'b0, '0, 1'b0, 1'b1));
    end else begin
      pending_graph_results.push_back(graph_result(hit, '0, 1'b0, 1'b1));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    uess_pkg::out_item_t want;
    if (!rst_ni) begin
      for (int v = 0; v < VERTICES; v++) adj_rows[v] = '0;
      vertex_total = '0;
      edge_total = '0;
      pending_graph_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_graph_results.size() == 0) begin
          log_mismatch($sformatf("result with nothing expected: vertex %0d valid %0d",
                                 out_i.listed_vertex, out_i.listed_valid));
        end else begin
          want = pending_graph_results.pop_front();
          compare_field("found", out_i.found, want.found);
          compare_field("listed_vertex", out_i.listed_vertex, want.listed_vertex);
          compare_field("listed_valid", out_i.listed_valid, want.listed_valid);
          compare_field("last", out_i.last, want.last);
          compare_field("vertex_count", out_i.vertex_count, want.vertex_count);
          compare_field("edge_count", out_i.edge_count, want.edge_count);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) apply_graph_command(in_i);
    end
    error_count_o     <= mismatches;
    results_waiting_o <= pending_graph_results.size();
    results_seen_o    <= results_seen;
    longest_list_o    <= longest_list;
  end

endmodule

// ===== test/undirected_edge_set_store_tb.sv =====
`timescale 1ns / 1ps

module undirected_edge_set_store_tb;

  localparam int         VERTICES     = 64;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         LONG_HOLD    = 300;
  localparam int         RANDOM_ITEMS = 172;
  localparam int         SETTLE       = 20;
  localparam logic [2:0] CMD_LAST_CODE = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  uess_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  uess_pkg::out_item_t out_data;

  int                  error_count;
  int                  results_waiting;
  int                  results_seen;
  int                  longest_list;
  int                  cycle_count;
  int                  items_sent;
  int                  holds_asked;
  int                  holds_done;
  int                  send_left;
  bit                  send_quiet;
  int                  pool_base;
  uess_pkg::in_item_t  recent_links [$];

  undirected_edge_set_store #(
    .VERTEX_COUNT(VERTICES)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  undirected_edge_set_store_checker graph_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_i             (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_i            (out_data),
    .error_count_o    (error_count),
    .results_waiting_o(results_waiting),
    .results_seen_o   (results_seen),
    .longest_list_o   (longest_list)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, results_waiting);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stretches of random gaps and stretches of none follow in random order
  function automatic int draw_gap(inout int left, inout bit quiet);
    if (left == 0) begin
      left = $urandom_range(8, 30);
      quiet = ($urandom_range(0, 2) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic uess_pkg::in_item_t make_item(input logic [2:0] cmd, input int a,
                                                   input int b);
    uess_pkg::in_item_t it;
    it.command  = cmd;
    it.vertex_a = 6'(a);
    it.vertex_b = 6'(b);
    return it;
  endfunction

  function automatic int pick_vertex();
    // mostly a small cluster so edges pile up on the same rows
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, VERTICES - 1);
    return pool_base + $urandom_range(0, 7);
  endfunction

  task automatic send_item(input uess_pkg::in_item_t it);
    int gap;
    gap = draw_gap(send_left, send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_waiting != 0);
  endtask

  task automatic send_random_item();
    uess_pkg::in_item_t it;
    uess_pkg::in_item_t link;
    int                 roll;
    roll = $urandom_range(0, 99);
    it = make_item(uess_pkg::CMD_CONNECT, pick_vertex(), pick_vertex());
    if (roll < 35) begin
      recent_links.push_back(it);
      if (recent_links.size() > 16) void'(recent_links.pop_front());
    end else if (roll < 78) begin
      it.command = (roll < 60) ? uess_pkg::CMD_DISCONNECT : uess_pkg::CMD_QUERY;
      // reuse a known edge most of the time, either way round
      if (recent_links.size() > 0 && $urandom_range(0, 3) != 0) begin
        link = recent_links[$urandom_range(0, recent_links.size() - 1)];
        it = link;
        it.command = (roll < 60) ? uess_pkg::CMD_DISCONNECT : uess_pkg::CMD_QUERY;
        if ($urandom_range(0, 1)) begin
          it.vertex_a = link.vertex_b;
          it.vertex_b = link.vertex_a;
        end
      end
    end else if (roll < 88) begin
      it.command = uess_pkg::CMD_NEIGHBOURS;
    end else if (roll < 96) begin
      it.command = uess_pkg::CMD_ACTIVE;
    end else begin
      it.command = 3'($urandom_range(int'(uess_pkg::CMD_ACTIVE) + 1, int'(CMD_LAST_CODE)));
    end
    send_item(it);
  endtask

  // receiver
  initial begin
    int gap;
    int left;
    bit quiet;
    left = 0;
    quiet = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end
      gap = draw_gap(left, quiet);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // sender
  initial begin
    int hub;
    int spoke;
    int tmp;
    int order [VERTICES];
    send_left = 0;
    send_quiet = 1'b0;
    pool_base = $urandom_range(0, VERTICES - 8);
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, duplicates, self-loops, reserved codes, all bits of each field
    send_item(make_item(uess_pkg::CMD_QUERY, 0, 0));
    send_item(make_item(uess_pkg::CMD_ACTIVE, 0, 0));
    send_item(make_item(uess_pkg::CMD_NEIGHBOURS, 63, 0));
    send_item(make_item(uess_pkg::CMD_DISCONNECT, 63, 63));
    send_item(make_item(uess_pkg::CMD_CONNECT, 0, 63));
    send_item(make_item(uess_pkg::CMD_CONNECT, 63, 0));
    send_item(make_item(uess_pkg::CMD_QUERY, 63, 0));
    send_item(make_item(uess_pkg::CMD_CONNECT, 42, 42));
    send_item(make_item(uess_pkg::CMD_QUERY, 42, 42));
    send_item(make_item(uess_pkg::CMD_NEIGHBOURS, 42, 0));
    send_item(make_item(uess_pkg::CMD_CONNECT, 0, 0));
    send_item(make_item(uess_pkg::CMD_NEIGHBOURS, 0, 63));
    send_item(make_item(uess_pkg::CMD_ACTIVE, 63, 63));
    for (int c = int'(uess_pkg::CMD_ACTIVE) + 1; c <= int'(CMD_LAST_CODE); c++) begin
      send_item(make_item(3'(c), 63, 63));
    end
    send_item(make_item(uess_pkg::CMD_DISCONNECT, 42, 42));
    send_item(make_item(uess_pkg::CMD_DISCONNECT, 42, 42));
    send_item(make_item(uess_pkg::CMD_CONNECT, 21, 42));
    send_item(make_item(uess_pkg::CMD_QUERY, 42, 21));
    send_item(make_item(uess_pkg::CMD_DISCONNECT, 63, 0));
    send_item(make_item(uess_pkg::CMD_DISCONNECT, 0, 0));
    send_item(make_item(uess_pkg::CMD_ACTIVE, 0, 0));
    send_item(make_item(uess_pkg::CMD_DISCONNECT, 21, 42));
    send_item(make_item(uess_pkg::CMD_ACTIVE, 21, 21));
    wait_drained();

    // one hub tied to every vertex, itself included, in shuffled order
    hub = $urandom_range(0, VERTICES - 1);
    for (int v = 0; v < VERTICES; v++) order[v] = v;
    for (int v = VERTICES - 1; v > 0; v--) begin
      spoke = $urandom_range(0, v);
      tmp = order[v];
      order[v] = order[spoke];
      order[spoke] = tmp;
    end
    for (int v = 0; v < VERTICES; v++) begin
      if ($urandom_range(0, 1)) send_item(make_item(uess_pkg::CMD_CONNECT, hub, order[v]));
      else send_item(make_item(uess_pkg::CMD_CONNECT, order[v], hub));
    end
    send_item(make_item(uess_pkg::CMD_NEIGHBOURS, hub, 0));
    send_item(make_item(uess_pkg::CMD_ACTIVE, 0, 0));
    for (int k = 0; k < 16; k++) begin
      send_item(make_item(uess_pkg::CMD_DISCONNECT, hub, $urandom_range(0, VERTICES - 1)));
    end
    send_item(make_item(uess_pkg::CMD_NEIGHBOURS, hub, 0));
    wait_drained();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 40) holds_asked++;
      send_random_item();
    end
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d command items, checked %0d results, longest list %0d entries",
             items_sent, results_seen, longest_list);
    $display("covered empty and full lists, self-loops, repeated updates and a long output stall");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
